// ----- hdl/psc_pkg.sv -----
// shared constants, types and lfsr helpers for the pike stream cipher
`default_nettype none
package psc_pkg;

  localparam logic [31:0] SEED_MIX    = 32'h0502_7919;
  localparam logic [31:0] MASK_ODD    = 32'hAAAA_AAAA;
  localparam logic [31:0] MASK_EVEN   = 32'h5555_5555;
  localparam logic [31:0] MASK_HI_NIB = 32'hF0F0_F0F0;
  localparam logic [31:0] MASK_LO_NIB = 32'h0F0F_0F0F;

  localparam int RING_COUNT = 3;
  localparam int RING_DEPTH = 64;
  localparam int RING_AW    = 6;
  localparam int WORD_W     = 32;

  localparam logic [RING_AW-1:0] LAG_A [RING_COUNT] = '{6'd55, 6'd57, 6'd58};
  localparam logic [RING_AW-1:0] LAG_B [RING_COUNT] = '{6'd24, 6'd7, 6'd19};
  localparam logic [RING_AW-1:0] RING_LAST = 6'd63;

  // lfsr steps done per fill cycle, and fill cycles per ring word
  localparam int STEPS_PER_CYCLE = 8;
  localparam int SUB_W           = 2;
  localparam logic [SUB_W-1:0] SUB_LAST = 2'd3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic OP_RESTART = 1'b0;
  localparam logic OP_BYTE    = 1'b1;

  typedef struct packed {
    logic       restart;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_FILL,
    ST_IDLE,
    ST_GEN
  } back_state_t;

  function automatic logic [WORD_W-1:0] lfsr_step(input logic [WORD_W-1:0] k);
    logic fb;
    fb = k[31] ^ k[6] ^ k[4] ^ k[2] ^ k[1] ^ k[0];
    return {fb, k[WORD_W-1:1]};
  endfunction

  function automatic logic [WORD_W-1:0] lfsr_multi(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] k;
    k = v;
    for (int i = 0; i < STEPS_PER_CYCLE; i++) begin
      k = lfsr_step(k);
    end
    return k;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/psc_if.sv -----
// handshake channel interfaces: input items, result items, seed writes
`default_nettype none
interface psc_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_in;
  logic       last_in;
  modport source (output valid, output op, output data_in, output last_in, input ready);
  modport sink   (input valid, input op, input data_in, input last_in, output ready);
endinterface

interface psc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic       last_out;
  modport source (output valid, output data_out, output last_out, input ready);
  modport sink   (input valid, input data_out, input last_out, output ready);
endinterface

interface psc_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/psc_ram.sv -----
// generic ram: one write port, two registered read ports
`default_nettype none
module psc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule
`default_nettype wire

// ----- hdl/psc_front.sv -----
// front end: takes input transfers, tags restarts, queues them for the back end
`default_nettype none
module psc_front (
  input  logic           clk,
  input  logic           rst_n,
  psc_in_if.sink         in_ch,
  output psc_pkg::cmd_t  cmd,
  output logic           cmd_valid,
  input  logic           cmd_pop
);
  import psc_pkg::*;

  cmd_t              queue_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;
  logic              pop;
  cmd_t              in_cmd;

  assign in_ch.ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (count_r != '0);
  assign pop         = cmd_pop && cmd_valid;
  assign cmd         = queue_r[rd_ptr_r];

  always_comb begin
    in_cmd.restart = (in_ch.op == OP_RESTART);
    in_cmd.data    = in_ch.data_in;
    in_cmd.last    = in_ch.last_in;
    wr_ptr_nxt     = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt     = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt      = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/psc_back.sv -----
// back end: ring fill, carry-majority word generation and byte output
`default_nettype none
module psc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [31:0]    seed,
  input  psc_pkg::cmd_t  cmd,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  psc_out_if.source      out_ch
);
  import psc_pkg::*;

  back_state_t        state_r, state_nxt;
  logic [RING_AW-1:0] pos_r    [RING_COUNT];
  logic [RING_AW-1:0] pos_nxt  [RING_COUNT];
  logic [WORD_W-1:0]  cur_r    [RING_COUNT];
  logic [WORD_W-1:0]  cur_nxt  [RING_COUNT];
  logic [WORD_W-1:0]  lfsr_r   [RING_COUNT];
  logic [WORD_W-1:0]  lfsr_nxt [RING_COUNT];
  logic [RING_COUNT-1:0] carry_r, carry_nxt;
  logic [RING_AW-1:0] fill_w_r, fill_w_nxt;
  logic [SUB_W-1:0]   fill_sub_r, fill_sub_nxt;
  logic [WORD_W-1:0]  key_word_r, key_word_nxt;
  logic [1:0]         byte_pos_r, byte_pos_nxt;
  logic               have_r, have_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_data_r, out_data_nxt;
  logic               out_last_r, out_last_nxt;

  logic [WORD_W-1:0]  start    [RING_COUNT];
  logic [WORD_W-1:0]  lfsr_adv [RING_COUNT];
  logic [WORD_W:0]    sum      [RING_COUNT];
  logic [WORD_W-1:0]  rdata_a  [RING_COUNT];
  logic [WORD_W-1:0]  rdata_b  [RING_COUNT];
  logic [RING_AW-1:0] raddr_a  [RING_COUNT];
  logic [RING_AW-1:0] raddr_b  [RING_COUNT];
  logic [RING_AW-1:0] waddr    [RING_COUNT];
  logic [WORD_W-1:0]  wdata    [RING_COUNT];
  logic [RING_COUNT-1:0] we;
  logic [RING_COUNT-1:0] go;
  logic               majority;
  logic               slot_free;
  logic [WORD_W-1:0]  mix;
  logic [WORD_W-1:0]  key_mix;

  assign mix = seed ^ SEED_MIX;
  assign start[0] = mix;
  assign start[1] = ((mix & MASK_ODD) >> 1) | ((mix & MASK_EVEN) << 1);
  assign start[2] = ~(((mix & MASK_HI_NIB) >> 4) | ((mix & MASK_LO_NIB) << 4));

  assign majority = (carry_r[0] & carry_r[1]) | (carry_r[0] & carry_r[2]) |
                    (carry_r[1] & carry_r[2]);
  assign slot_free = !out_valid_r || out_ch.ready;

  genvar g;
  generate
    for (g = 0; g < RING_COUNT; g++) begin : g_ring
      // read addresses always point at the lags of the next step
      assign raddr_a[g]  = pos_r[g] + 6'd1 - LAG_A[g];
      assign raddr_b[g]  = pos_r[g] + 6'd1 - LAG_B[g];
      assign sum[g]      = {1'b0, rdata_a[g]} + {1'b0, rdata_b[g]};
      assign lfsr_adv[g] = lfsr_multi(lfsr_r[g]);
      // a ring steps when its carry matches the majority carry
      assign go[g]       = (carry_r[g] == majority);

      psc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RING_DEPTH)
      ) u_ring_ram (
        .clk     (clk),
        .we      (we[g]),
        .waddr   (waddr[g]),
        .wdata   (wdata[g]),
        .raddr_a (raddr_a[g]),
        .raddr_b (raddr_b[g]),
        .rdata_a (rdata_a[g]),
        .rdata_b (rdata_b[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    cur_nxt       = cur_r;
    lfsr_nxt      = lfsr_r;
    carry_nxt     = carry_r;
    fill_w_nxt    = fill_w_r;
    fill_sub_nxt  = fill_sub_r;
    key_word_nxt  = key_word_r;
    byte_pos_nxt  = byte_pos_r;
    have_nxt      = have_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    cmd_pop       = 1'b0;
    we            = '0;
    key_mix       = '0;
    for (int r = 0; r < RING_COUNT; r++) begin
      waddr[r] = fill_w_r;
      wdata[r] = lfsr_adv[r];
    end

    case (state_r)
      ST_LOAD: begin
        for (int r = 0; r < RING_COUNT; r++) begin
          lfsr_nxt[r] = lfsr_step(start[r]);
        end
        fill_w_nxt   = '0;
        fill_sub_nxt = '0;
        key_word_nxt = '0;
        byte_pos_nxt = '0;
        have_nxt     = 1'b0;
        state_nxt    = ST_FILL;
      end
      ST_FILL: begin
        lfsr_nxt     = lfsr_adv;
        fill_sub_nxt = fill_sub_r + 1'b1;
        if (fill_sub_r == SUB_LAST) begin
          we         = '1;
          fill_w_nxt = fill_w_r + 1'b1;
          if (fill_w_r == RING_LAST) begin
            for (int r = 0; r < RING_COUNT; r++) begin
              pos_nxt[r] = RING_LAST;
              cur_nxt[r] = lfsr_adv[r];
            end
            carry_nxt = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.restart) begin
            cmd_pop   = 1'b1;
            state_nxt = ST_LOAD;
          end else if (byte_pos_r != 2'd0 || have_r) begin
            if (slot_free) begin
              cmd_pop       = 1'b1;
              out_valid_nxt = 1'b1;
              out_data_nxt  = cmd.data ^ key_word_r[{byte_pos_r, 3'b000} +: 8];
              out_last_nxt  = cmd.last;
              byte_pos_nxt  = byte_pos_r + 1'b1;
              have_nxt      = 1'b0;
            end
          end else begin
            // lag words are read this cycle, summed in the next
            state_nxt = ST_GEN;
          end
        end
      end
      ST_GEN: begin
        for (int r = 0; r < RING_COUNT; r++) begin
          waddr[r] = pos_r[r] + 6'd1;
          wdata[r] = sum[r][WORD_W-1:0];
          if (go[r]) begin
            we[r]        = 1'b1;
            pos_nxt[r]   = pos_r[r] + 6'd1;
            cur_nxt[r]   = sum[r][WORD_W-1:0];
            carry_nxt[r] = sum[r][WORD_W];
          end
          key_mix = key_mix ^ cur_nxt[r];
        end
        key_word_nxt = key_mix;
        have_nxt     = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      carry_r     <= '0;
      fill_w_r    <= '0;
      fill_sub_r  <= '0;
      key_word_r  <= '0;
      byte_pos_r  <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < RING_COUNT; r++) begin
        pos_r[r] <= RING_LAST;
      end
    end else begin
      state_r     <= state_nxt;
      carry_r     <= carry_nxt;
      fill_w_r    <= fill_w_nxt;
      fill_sub_r  <= fill_sub_nxt;
      key_word_r  <= key_word_nxt;
      byte_pos_r  <= byte_pos_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    lfsr_r     <= lfsr_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.data_out = out_data_r;
  assign out_ch.last_out = out_last_r;

endmodule
`default_nettype wire

// ----- hdl/pike_stream_cipher.sv -----
// pike stream cipher: a byte goes from its input transfer through the front-end queue and
// the back end's output step into the output register; a byte that opens a new keystream
// word first waits for the lag read issue step and the add/write step of the back end
// each keystream word serves four bytes; a restart item holds the back end for a pop step,
// a load step and the lfsr fill of all 64 ring words; after reset the seed is 0 and the
// same load and fill (no pop) runs on its own; input transfers are queued meanwhile, up to four
`default_nettype none
module pike_stream_cipher (
  input  logic       clk,
  input  logic       rst_n,
  psc_in_if.sink     in_ch,
  psc_out_if.source  out_ch,
  psc_cfg_if.sink    cfg_ch
);
  import psc_pkg::*;

  logic [31:0] seed_r;
  cmd_t        cmd;
  logic        cmd_valid;
  logic        cmd_pop;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      seed_r <= cfg_ch.data;
    end
  end

  psc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  psc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .seed      (seed_r),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire
